@@ design/usr_pkg.sv @@
// Shared types and constants for the undo slot remapper.
`timescale 1ns / 1ps
`default_nettype none
package usr_pkg;

  localparam int SLOT_COUNT_DEF = 4;   // legal range 3..4
  localparam int SLOT_W         = 2;
  localparam int USED_W         = 3;
  localparam int CNT_W          = 64;
  localparam int MAP_DEPTH      = 4;
  localparam int FIRST_NORMAL   = 2;

  // fixed slots
  localparam logic [SLOT_W-1:0] SLOT_OLD  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_DEAD = 2'd1;

  // map contents at run start: entry 0 -> 0, entry 1 -> 1, others empty
  localparam logic [MAP_DEPTH-1:0]             MAP_RST_VLD  = 4'b0011;
  localparam logic [MAP_DEPTH-1:0][SLOT_W-1:0] MAP_RST_SLOT = 8'b00_00_01_00;

  // config register map (64-bit registers at 8-byte stride)
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_OFS_W  = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_OFS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INVALID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OLDEST  = 2'd2;

  localparam logic [CNT_W-1:0] DEAD_RST    = 64'd1;
  localparam logic [CNT_W-1:0] INVALID_RST = 64'd0;
  localparam logic [CNT_W-1:0] OLDEST_RST  = 64'd0;

  localparam int IN_TDATA_W  = 72;  // 2 + 64 padded to bytes
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  typedef struct packed {
    logic              run_start;
    logic              is_target;
    logic [CNT_W-1:0]  element_counter;
    logic [SLOT_W-1:0] orig_slot;
  } usr_item_t;

  typedef struct packed {
    logic              allocated;
    logic              new_group;
    logic [SLOT_W-1:0] new_slot;
  } usr_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] dead_counter;
    logic [CNT_W-1:0] invalid_counter;
    logic [CNT_W-1:0] oldest_counter;
  } usr_cfg_t;

endpackage : usr_pkg
`default_nettype wire

@@ design/usr_in_stage.sv @@
// Input register stage: captures one beat and unpacks its fields.
`timescale 1ns / 1ps
`default_nettype none
module usr_in_stage
  import usr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // orig_slot, element_counter, pad
  input  wire logic [IN_TUSER_W-1:0] in_tuser,   // is_target, run_start
  input  wire logic                  take,
  output logic                       item_vld,
  output usr_item_t                  item
);

  logic      vld_r;
  usr_item_t item_r;

  assign in_tready = !vld_r || take;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.orig_slot       <= in_tdata[SLOT_W-1:0];
      item_r.element_counter <= in_tdata[SLOT_W+CNT_W-1:SLOT_W];
      item_r.is_target       <= in_tuser[0];
      item_r.run_start       <= in_tuser[1];
    end
  end

endmodule : usr_in_stage
`default_nettype wire

@@ design/usr_slot_table.sv @@
// Slot table, per-run map and combinational slot assignment.
`timescale 1ns / 1ps
`default_nettype none
module usr_slot_table
  import usr_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire usr_item_t item,
  input  wire usr_cfg_t  cfg,
  output usr_res_t       res
);

  localparam int NORM = SLOT_COUNT - FIRST_NORMAL;
  localparam logic [USED_W-1:0] USED_FULL = USED_W'(SLOT_COUNT);
  localparam logic [USED_W-1:0] USED_RST  = USED_W'(FIRST_NORMAL);

  logic [MAP_DEPTH-1:0]             map_vld_r, map_vld_nxt;
  logic [MAP_DEPTH-1:0][SLOT_W-1:0] map_slot_r, map_slot_nxt;
  logic [NORM-1:0][CNT_W-1:0]       cnt_r;
  logic [USED_W-1:0]                used_r, used_nxt;

  logic [MAP_DEPTH-1:0]             eff_vld;
  logic [MAP_DEPTH-1:0][SLOT_W-1:0] eff_slot;
  logic [USED_W-1:0]                eff_used;
  logic [USED_W-1:0]                alloc_pos;
  logic [SLOT_W-1:0]                norm_slot, slot;
  logic hit_dead, below_old, hit_inv, norm_hit, full, use_map, regroup, alloc;
  logic map_ok;

  always_comb begin
    // run start clears the run state before the element is handled
    eff_used = item.run_start ? USED_RST     : used_r;
    eff_vld  = item.run_start ? MAP_RST_VLD  : map_vld_r;
    eff_slot = item.run_start ? MAP_RST_SLOT : map_slot_r;

    hit_dead  = item.element_counter == cfg.dead_counter;
    below_old = item.element_counter <  cfg.oldest_counter;
    hit_inv   = item.element_counter == cfg.invalid_counter;

    // first matching normal slot wins: scan high to low
    norm_hit  = 1'b0;
    norm_slot = SLOT_OLD;
    for (int k = NORM - 1; k >= 0; k--) begin
      if ((USED_W'(k + FIRST_NORMAL) < eff_used) && (item.element_counter == cnt_r[k])) begin
        norm_hit  = 1'b1;
        norm_slot = SLOT_W'(k + FIRST_NORMAL);
      end
    end

    full    = eff_used >= USED_FULL;
    use_map = !item.is_target && eff_vld[item.orig_slot];

    regroup   = 1'b0;
    alloc     = 1'b0;
    alloc_pos = eff_used;
    if (use_map) begin
      slot = eff_slot[item.orig_slot];
    end else if (hit_dead) begin
      slot = SLOT_DEAD;
    end else if (below_old || hit_inv) begin
      slot = SLOT_OLD;
    end else if (norm_hit) begin
      slot = norm_slot;
    end else if (!full) begin
      alloc = 1'b1;
      slot  = eff_used[SLOT_W-1:0];
    end else begin
      // table full: fresh group, the element lands in the first normal slot
      regroup   = 1'b1;
      alloc     = 1'b1;
      alloc_pos = USED_RST;
      slot      = SLOT_W'(FIRST_NORMAL);
    end

    map_vld_nxt  = regroup ? MAP_RST_VLD  : eff_vld;
    map_slot_nxt = regroup ? MAP_RST_SLOT : eff_slot;
    if (!item.is_target && !use_map) begin
      map_vld_nxt[item.orig_slot]  = 1'b1;
      map_slot_nxt[item.orig_slot] = slot;
    end

    if (regroup) begin
      used_nxt = USED_RST + USED_W'(1);
    end else if (alloc) begin
      used_nxt = eff_used + USED_W'(1);
    end else begin
      used_nxt = eff_used;
    end

    res.new_slot  = slot;
    res.new_group = regroup;
    res.allocated = alloc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r  <= MAP_RST_VLD;
      map_slot_r <= MAP_RST_SLOT;
      used_r     <= USED_RST;
    end else if (step) begin
      map_vld_r  <= map_vld_nxt;
      map_slot_r <= map_slot_nxt;
      used_r     <= used_nxt;
    end
  end

  // counters are read only below used_r, so they need no clearing
  always_ff @(posedge clk) begin
    for (int k = 0; k < NORM; k++) begin
      if (step && alloc && (alloc_pos == USED_W'(k + FIRST_NORMAL))) begin
        cnt_r[k] <= item.element_counter;
      end
    end
  end

  always_comb begin
    map_ok = 1'b1;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      if (map_vld_r[i] && !(USED_W'(map_slot_r[i]) < used_r)) begin
        map_ok = 1'b0;
      end
    end
  end

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r >= USED_RST) && (used_r <= USED_FULL))
    else $error("slots_used out of range");

  a_map_in_table: assert property (@(posedge clk) disable iff (!rst_n) map_ok)
    else $error("map entry points past the used slots");

  a_regroup_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.new_group |-> res.allocated && (res.new_slot == SLOT_W'(FIRST_NORMAL)))
    else $error("new group without allocation in first normal slot");

  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.allocated && !res.new_group |=> used_r == $past(eff_used) + USED_W'(1))
    else $error("allocation did not grow the table by one");

endmodule : usr_slot_table
`default_nettype wire

@@ design/undo_slot_remapper.sv @@
// Top level of the undo slot remapper: config registers, stages, result register.
`timescale 1ns / 1ps
`default_nettype none
// One beat in gives one beat out. Each element is mapped to a slot of a fresh
// table: slot 1 for the dead counter, slot 0 for counters older than
// oldest_counter or equal to invalid_counter, else a reused or newly allocated
// normal slot (2 .. SLOT_COUNT-1). Non-target elements cache their slot per
// original slot number until run_start (tuser bit 1) or a new group clears
// map and table. When no normal slot is left, a new group starts at the
// element: new_group and allocated are set and it takes the first normal slot.
// Throughput is one beat per clock while out_tready is held high; a beat passes
// the input register, then the result register. The rate is set by the slot
// table, whose compares and map lookup are combinational for each element.
// Config registers (64-bit, byte address 8*i): 0 dead_counter (reset 1),
// 1 invalid_counter (reset 0), 2 oldest_counter (reset 0). Write them only
// while no beat is in flight.
module undo_slot_remapper
  import usr_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] orig_slot, [65:2] element_counter
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // [0] is_target, [1] run_start
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [1:0] new_slot
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // [0] new_group, [1] allocated
  // config port
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CNT_W-1:0]       cfg_pwdata,
  output logic [CNT_W-1:0]            cfg_prdata,
  output logic                        cfg_pready
);

  usr_cfg_t  cfg_r;
  usr_item_t item;
  usr_res_t  res;
  usr_res_t  res_r;
  logic      item_vld;
  logic      take;
  logic      out_vld_r;
  logic      cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  // config registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:CFG_OFS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_counter    <= DEAD_RST;
      cfg_r.invalid_counter <= INVALID_RST;
      cfg_r.oldest_counter  <= OLDEST_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_IDX_DEAD:    cfg_r.dead_counter    <= cfg_pwdata;
        CFG_IDX_INVALID: cfg_r.invalid_counter <= cfg_pwdata;
        CFG_IDX_OLDEST:  cfg_r.oldest_counter  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_IDX_DEAD:    cfg_prdata = cfg_r.dead_counter;
      CFG_IDX_INVALID: cfg_prdata = cfg_r.invalid_counter;
      CFG_IDX_OLDEST:  cfg_prdata = cfg_r.oldest_counter;
      default:         cfg_prdata = '0;
    endcase
  end

  // the held beat is processed whenever the result register can take it
  assign take = item_vld && (!out_vld_r || out_tready);

  usr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .item_vld  (item_vld),
    .item      (item)
  );

  usr_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - SLOT_W){1'b0}}, res_r.new_slot};
  assign out_tuser  = {res_r.allocated, res_r.new_group};

endmodule : undo_slot_remapper
`default_nettype wire
